>>> rtl/qddb_pkg.sv
package qddb_pkg;

    localparam int NUM_ENCODERS_DEF = 8;
    localparam int MAX_ENCODERS     = 8;
    localparam int WORD_W           = 16;
    localparam int PAIR_W           = 2;
    localparam int MASK_W           = 8;
    localparam int ACC_W            = 4;
    localparam int DETENT_W         = 3;

    localparam logic [DETENT_W-1:0] DETENT_RESET   = 3'd4;
    localparam logic [WORD_W-1:0]   WORD_RESET     = '1;
    localparam logic [PAIR_W-1:0]   PAIR_MASK      = 2'h3;

    typedef logic signed [1:0] dir_t;

    localparam dir_t DIR_NONE  = 2'sb00;
    localparam dir_t DIR_PLUS  = 2'sb01;
    localparam dir_t DIR_MINUS = 2'sb11;

    typedef struct packed {
        logic step;
        logic up;
    } lane_res_t;

    // Row is the old pair state, column the new one.
    function automatic dir_t quad_dir(input logic [PAIR_W-1:0] old_pair,
                                      input logic [PAIR_W-1:0] new_pair);
        dir_t d;
        d = DIR_NONE;
        case ({old_pair, new_pair})
            4'b00_01: d = DIR_MINUS;
            4'b00_10: d = DIR_PLUS;
            4'b01_00: d = DIR_PLUS;
            4'b01_11: d = DIR_MINUS;
            4'b10_00: d = DIR_MINUS;
            4'b10_11: d = DIR_PLUS;
            4'b11_01: d = DIR_PLUS;
            4'b11_10: d = DIR_MINUS;
            default:  d = DIR_NONE;
        endcase
        return d;
    endfunction

endpackage

>>> rtl/qddb_ifs.sv
interface qddb_in_if;
    logic                          valid;
    logic                          ready;
    logic [qddb_pkg::WORD_W-1:0]   pin_word;
    logic                          read_ok;

    modport source (output valid, output pin_word, output read_ok, input ready);
    modport sink   (input valid, input pin_word, input read_ok, output ready);
endinterface

interface qddb_out_if;
    logic                          valid;
    logic                          ready;
    logic [qddb_pkg::MASK_W-1:0]   step_mask;
    logic [qddb_pkg::MASK_W-1:0]   step_up_mask;

    modport source (output valid, output step_mask, output step_up_mask, input ready);
    modport sink   (input valid, input step_mask, input step_up_mask, output ready);
endinterface

>>> rtl/qddb_lane.sv
module qddb_lane (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              capture,
    input  logic [qddb_pkg::PAIR_W-1:0]       pair_now,
    input  logic [qddb_pkg::DETENT_W-1:0]     detent,
    output qddb_pkg::lane_res_t               res
);

    localparam int AccW = qddb_pkg::ACC_W;

    logic [qddb_pkg::PAIR_W-1:0]  pair_reg;
    logic [qddb_pkg::PAIR_W-1:0]  pair_next;
    logic signed [AccW-1:0]       acc_reg;
    logic signed [AccW-1:0]       acc_next;

    qddb_pkg::dir_t               dir;
    logic                         changed;
    logic signed [AccW-1:0]       dir_ext;
    logic signed [AccW-1:0]       acc_sum;
    logic signed [AccW-1:0]       detent_pos;
    logic signed [AccW-1:0]       detent_neg;
    logic                         hit;
    logic                         moving;

    always_comb
    begin
        changed    = (pair_now & qddb_pkg::PAIR_MASK) != pair_reg;
        dir        = qddb_pkg::quad_dir(pair_reg, pair_now);
        dir_ext    = {{(AccW-2){dir[1]}}, dir};
        acc_sum    = acc_reg + dir_ext;
        detent_pos = {{(AccW-qddb_pkg::DETENT_W){1'b0}}, detent};
        detent_neg = -detent_pos;
        // count of zero behaves like one: every transition hits
        hit        = (acc_sum >= detent_pos) || (acc_sum <= detent_neg);
        moving     = advance && changed && (dir != qddb_pkg::DIR_NONE);

        pair_next = pair_reg;
        acc_next  = acc_reg;
        if (capture || (advance && changed))
        begin
            pair_next = pair_now;
        end
        if (moving)
        begin
            acc_next = hit ? '0 : acc_sum;
        end

        res.step = moving && hit;
        res.up   = moving && hit && (acc_sum > 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
            acc_reg  <= '0;
        end
        else
        begin
            pair_reg <= pair_next;
            acc_reg  <= acc_next;
        end
    end

endmodule

>>> rtl/qddb_merge.sv
module qddb_merge #(
    parameter int NUM_ENCODERS = qddb_pkg::NUM_ENCODERS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  accept,
    input  qddb_pkg::lane_res_t   lane_res [NUM_ENCODERS],
    output logic                  can_take,
    qddb_out_if.source            result
);

    logic                          valid_reg;
    logic                          valid_next;
    logic [qddb_pkg::MASK_W-1:0]   step_reg;
    logic [qddb_pkg::MASK_W-1:0]   up_reg;
    logic [qddb_pkg::MASK_W-1:0]   step_vec;
    logic [qddb_pkg::MASK_W-1:0]   up_vec;

    genvar k;
    generate
        for (k = 0; k < qddb_pkg::MASK_W; k++)
        begin : g_bit
            if (k < NUM_ENCODERS)
            begin : g_lane
                assign step_vec[k] = lane_res[k].step;
                assign up_vec[k]   = lane_res[k].up;
            end
            else
            begin : g_none
                assign step_vec[k] = 1'b0;
                assign up_vec[k]   = 1'b0;
            end
        end
    endgenerate

    // output register frees up in the same cycle it is drained
    assign can_take = !valid_reg || result.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            step_reg <= step_vec;
            up_reg   <= up_vec;
        end
    end

    assign result.valid        = valid_reg;
    assign result.step_mask    = step_reg;
    assign result.step_up_mask = up_reg;

endmodule

>>> rtl/quadrature_detent_decoder_bank_top.sv
// Channel   Dir  Payload                         Handshake
// sample    in   pin_word[15:0], read_ok         valid / ready
// result    out  step_mask[7:0], step_up_mask    valid / ready
// cfg       in   cfg_data[2:0] detent count      cfg_we, no wait
//
// One request per cycle unless stalled; masks follow in the cycle after accept.
// Each encoder lane holds its pair state and accumulator in registers.
// Reset clears all lanes, sets the last good word to all ones, count to 4.
// First request after reset just captures pairs (if read_ok); masks are zero.
// sample.ready drops only while a result sits unread and result.ready is low.
module quadrature_detent_decoder_bank_top #(
    parameter int NUM_ENCODERS = qddb_pkg::NUM_ENCODERS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [qddb_pkg::DETENT_W-1:0]     cfg_data,
    qddb_in_if.sink                           sample,
    qddb_out_if.source                        result
);

    logic [qddb_pkg::DETENT_W-1:0]  detent_reg;
    logic [qddb_pkg::WORD_W-1:0]    last_good_reg;
    logic [qddb_pkg::WORD_W-1:0]    last_good_next;
    logic                           primed_reg;
    logic                           primed_next;

    logic                           accept;
    logic                           can_take;
    logic [qddb_pkg::WORD_W-1:0]    word;
    logic                           advance;
    logic                           capture;

    qddb_pkg::lane_res_t            lane_res [NUM_ENCODERS];

    assign sample.ready = can_take;
    assign accept       = sample.valid && can_take;
    // a bad read replays the last good word, so no pair moves
    assign word         = sample.read_ok ? sample.pin_word : last_good_reg;
    assign advance      = accept && primed_reg;
    assign capture      = accept && !primed_reg && sample.read_ok;

    always_comb
    begin
        last_good_next = last_good_reg;
        primed_next    = primed_reg;
        if (accept)
        begin
            primed_next = 1'b1;
            if (sample.read_ok)
            begin
                last_good_next = sample.pin_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            detent_reg    <= qddb_pkg::DETENT_RESET;
            last_good_reg <= qddb_pkg::WORD_RESET;
            primed_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                detent_reg <= cfg_data;
            end
            last_good_reg <= last_good_next;
            primed_reg    <= primed_next;
        end
    end

    genvar k;
    generate
        for (k = 0; k < NUM_ENCODERS; k++)
        begin : g_lane
            qddb_lane u_lane (
                .clk      (clk),
                .rst_n    (rst_n),
                .advance  (advance),
                .capture  (capture),
                .pair_now (word[qddb_pkg::PAIR_W*k +: qddb_pkg::PAIR_W]),
                .detent   (detent_reg),
                .res      (lane_res[k])
            );
        end
    endgenerate

    qddb_merge #(
        .NUM_ENCODERS (NUM_ENCODERS)
    ) u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .lane_res (lane_res),
        .can_take (can_take),
        .result   (result)
    );

endmodule
